// File: design/pru_pkg.sv
// Package for the pixel replication upscaler.
// Holds register indexes, operation codes, clamp limits and pipeline record types.
// No dependencies.
`default_nettype none

package pru_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SCALE     = 2'd0,
    CFG_ROW_WIDTH = 2'd1,
    CFG_ROW_COUNT = 2'd2
  } cfg_index_t;

  // Input item kinds
  localparam logic OP_PIXEL  = 1'b0;
  localparam logic OP_REPLAY = 1'b1;

  // Field widths fixed by the interface
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned SCALE_W = 7;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned PIXEL_W = 3 * COLOR_W;

  // Clamp limits
  localparam logic [SCALE_W-1:0] MAX_SCALE = 7'd100;
  localparam logic [DIM_W-1:0]   MAX_ROWS  = 13'd4096;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [PIXEL_W-1:0] pixel_t;

  // Per-item record carried from the input register to the result register
  typedef struct packed {
    logic               replay;
    pixel_t             pixel;
    logic [SCALE_W-1:0] copies;
    logic [1:0]         pad_bytes;
    logic               row_end;
    logic               image_end;
    logic               order_error;
  } item_t;

endpackage : pru_pkg

`default_nettype wire

// File: design/pixel_replication_upscaler.sv
// Integer nearest-neighbor upscaler for 24-bit RGB rows, top level.
// Depends on pru_pkg and pru_ram.
//
// Usage:
//   Program scale, row_width and row_count through the cfg_ write port while idle.
//   Feed each input row as row_width pixel transactions (operation = pixel), then
//   row_width*(scale-1) replay transactions; each replay returns the next buffered
//   pixel, so every row comes out scale times. Every input transaction yields one
//   result transaction: a color, the run length (copies = scale), and at the last
//   run of an output row row_end with the pad byte count (width*scale mod 4).
//   The last run of the image also carries image_end. A transaction of the wrong
//   kind returns order_error with all other fields zero and leaves state alone.
// Timing:
//   One transaction accepted per cycle while in_stall is low; each result passes
//   through the line buffer read register, then the result register. The row
//   position and replay counters update in the accept cycle, so the next
//   transaction may follow at once.
// Reset:
//   rst_n (synchronous) empties the pipeline, zeros the counters and sets the
//   configuration registers to 1. The line buffer is not cleared.
// Stall:
//   When out_stall holds the result register full, one more transaction is taken
//   into the read stage; after that in_stall rises until the result drains.
`default_nettype none

module pixel_replication_upscaler #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [pru_pkg::DIM_W-1:0]    cfg_data,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_operation,
  input  wire logic [pru_pkg::COLOR_W-1:0]  in_red,
  input  wire logic [pru_pkg::COLOR_W-1:0]  in_green,
  input  wire logic [pru_pkg::COLOR_W-1:0]  in_blue,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [pru_pkg::COLOR_W-1:0]  out_red,
  output logic      [pru_pkg::COLOR_W-1:0]  out_green,
  output logic      [pru_pkg::COLOR_W-1:0]  out_blue,
  output logic      [pru_pkg::SCALE_W-1:0]  out_copies,
  output logic      [1:0]                   out_pad_bytes,
  output logic                              out_row_end,
  output logic                              out_image_end,
  output logic                              out_order_error
);

  import pru_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Configuration registers
  logic [SCALE_W-1:0] scale_r;
  logic [DIM_W-1:0]   row_width_r;
  logic [DIM_W-1:0]   row_count_r;

  // Control state
  logic [AW-1:0]      col_r,      col_nxt;
  logic [SCALE_W-1:0] replays_r,  replays_nxt;
  logic [ROW_W-1:0]   row_idx_r,  row_idx_nxt;

  // Pipeline
  logic  s1_valid_r;
  item_t s1_r, s1_nxt;
  logic  out_valid_r;
  item_t out_r, out_nxt;
  pixel_t ram_rdata;

  // Effective (clamped) configuration
  logic [SCALE_W-1:0] scale_eff;
  logic [31:0]        width_eff;
  logic [DIM_W-1:0]   rows_eff;

  logic in_accept;
  logic s1_advance;
  logic is_replay;
  logic order_err;
  logic row_end;
  logic image_end;
  logic ram_en;
  logic ram_we;

  // Clamp registers to their legal ranges
  always_comb begin
    priority if (scale_r == '0) begin
      scale_eff = SCALE_W'(1);
    end else if (scale_r > MAX_SCALE) begin
      scale_eff = MAX_SCALE;
    end else begin
      scale_eff = scale_r;
    end

    priority if (row_width_r == '0) begin
      width_eff = 32'd1;
    end else if (32'(row_width_r) > 32'(MAX_WIDTH)) begin
      width_eff = 32'(MAX_WIDTH);
    end else begin
      width_eff = 32'(row_width_r);
    end

    priority if (row_count_r == '0) begin
      rows_eff = DIM_W'(1);
    end else if (row_count_r > MAX_ROWS) begin
      rows_eff = MAX_ROWS;
    end else begin
      rows_eff = row_count_r;
    end
  end

  // Handshake: the read stage moves on when the result register is free or taken
  assign s1_advance = !out_valid_r || !out_stall;
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  // Decode one transaction and step the row counters
  always_comb begin
    is_replay   = (in_operation == OP_REPLAY);
    order_err   = (is_replay != (replays_r != '0));
    row_end     = (32'(col_r) + 32'd1) >= width_eff;
    image_end   = 1'b0;
    col_nxt     = col_r;
    replays_nxt = replays_r;
    row_idx_nxt = row_idx_r;

    if (!order_err) begin
      if (row_end) begin
        col_nxt = '0;
        if (is_replay) begin
          replays_nxt = replays_r - SCALE_W'(1);
        end else begin
          replays_nxt = scale_eff - SCALE_W'(1);
        end
        if (replays_nxt == '0) begin
          if ((DIM_W'(row_idx_r) + DIM_W'(1)) >= rows_eff) begin
            image_end   = 1'b1;
            row_idx_nxt = '0;
          end else begin
            row_idx_nxt = row_idx_r + ROW_W'(1);
          end
        end
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end

    s1_nxt.replay      = is_replay && !order_err;
    s1_nxt.pixel       = {in_blue, in_green, in_red};
    s1_nxt.copies      = order_err ? '0 : scale_eff;
    s1_nxt.pad_bytes   = (!order_err && row_end) ? 2'(width_eff[1:0] * scale_eff[1:0]) : 2'd0;
    s1_nxt.row_end     = !order_err && row_end;
    s1_nxt.image_end   = !order_err && image_end;
    s1_nxt.order_error = order_err;
  end

  // Line buffer: store new pixels, read back on replay
  assign ram_en = in_accept && !order_err;
  assign ram_we = !is_replay;

  pru_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (col_r),
    .wdata ({in_blue, in_green, in_red}),
    .rdata (ram_rdata)
  );

  // Pick the buffered pixel for replays, zero on order error
  always_comb begin
    out_nxt = s1_r;
    if (s1_r.order_error) begin
      out_nxt.pixel = '0;
    end else if (s1_r.replay) begin
      out_nxt.pixel = ram_rdata;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= SCALE_W'(1);
      row_width_r <= DIM_W'(1);
      row_count_r <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCALE:     scale_r     <= cfg_data[SCALE_W-1:0];
        CFG_ROW_WIDTH: row_width_r <= cfg_data;
        CFG_ROW_COUNT: row_count_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Control state and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      replays_r   <= '0;
      row_idx_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        col_r     <= col_nxt;
        replays_r <= replays_nxt;
        row_idx_r <= row_idx_nxt;
      end
      if (s1_advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  // Payload registers: load on advance, hold while stalled
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_advance && s1_valid_r) begin
      out_r <= out_nxt;
    end
  end

  // Drive the result channel
  assign out_valid       = out_valid_r;
  assign out_red         = out_r.pixel[COLOR_W-1:0];
  assign out_green       = out_r.pixel[2*COLOR_W-1:COLOR_W];
  assign out_blue        = out_r.pixel[3*COLOR_W-1:2*COLOR_W];
  assign out_copies      = out_r.copies;
  assign out_pad_bytes   = out_r.pad_bytes;
  assign out_row_end     = out_r.row_end;
  assign out_image_end   = out_r.image_end;
  assign out_order_error = out_r.order_error;

endmodule : pixel_replication_upscaler

`default_nettype wire

// File: design/pru_ram.sv
// Generic single-port RAM with registered read data.
// Read data updates only on an enabled read and holds otherwise. No dependencies.
`default_nettype none

module pru_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                                         clk,
  input  wire logic                                         en,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                             wdata,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata <= mem_r[addr];
      end
    end
  end

endmodule : pru_ram

`default_nettype wire

// File: design/pru_checker.sv
// Port-level checker for the pixel replication upscaler, bound to the top level.
// Depends on pru_pkg for field widths.
`default_nettype none

module pru_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [pru_pkg::SCALE_W-1:0]  out_copies,
  input wire logic [1:0]                   out_pad_bytes,
  input wire logic                         out_row_end,
  input wire logic                         out_image_end,
  input wire logic                         out_order_error
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // An order error carries no run information
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_order_error |->
      out_copies == '0 && out_pad_bytes == 2'd0 && !out_row_end && !out_image_end)
    else $error("order error transaction carries run fields");

  // A good run always has at least one copy
  a_copies_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_order_error |-> out_copies != '0)
    else $error("run with zero copies");

  // Image end only on a row end
  a_image_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_end |-> out_row_end)
    else $error("image end without row end");

  // Padding only at the end of a row
  a_pad_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_row_end |-> out_pad_bytes == 2'd0)
    else $error("padding inside a row");

endmodule : pru_checker

bind pixel_replication_upscaler pru_checker u_pru_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_copies      (out_copies),
  .out_pad_bytes   (out_pad_bytes),
  .out_row_end     (out_row_end),
  .out_image_end   (out_image_end),
  .out_order_error (out_order_error)
);

`default_nettype wire

// File: tb/sv/pixel_replication_upscaler_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pixel_replication_upscaler: drives pixel and replay transactions,
// predicts every emitted run in a small tracker class and compares each result field.
// Depends on pru_pkg and the pixel_replication_upscaler top level.

module pixel_replication_upscaler_tb;
  import pru_pkg::*;

  localparam int unsigned LINE_DEPTH     = 4096;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned ORDER_SLIP_PCT = 6;
  localparam int unsigned REPORT_CAP     = 100;
  localparam int unsigned PHASE_ITEMS    = 30;
  localparam int unsigned SAT_ITEMS      = 20;

  // One emitted pixel run as it appears on the result channel
  typedef struct packed {
    color_t             red;
    color_t             green;
    color_t             blue;
    logic [SCALE_W-1:0] copies;
    logic [1:0]         pad;
    logic               row_end;
    logic               image_end;
    logic               order_error;
  } run_t;

  // Tracks line buffer, row position and owed replays; holds the runs still due
  class pixel_run_tracker;
    pixel_t             line_buf [LINE_DEPTH];
    int unsigned        column;
    int unsigned        replays_owed;
    int unsigned        row_index;
    int unsigned        written_depth;
    logic [SCALE_W-1:0] scale_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   count_reg;
    run_t               runs_due[$];
    int unsigned        mismatches;
    int unsigned        runs_matched;
    int unsigned        items_taken;
    int unsigned        order_errors;
    int unsigned        row_ends;
    int unsigned        image_ends;

    function new();
      column        = 0;
      replays_owed  = 0;
      row_index     = 0;
      written_depth = 0;
      scale_reg     = 1;
      width_reg     = 1;
      count_reg     = 1;
      mismatches    = 0;
      runs_matched  = 0;
      items_taken   = 0;
      order_errors  = 0;
      row_ends      = 0;
      image_ends    = 0;
    endfunction

    function int unsigned clamp_to(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function void write_reg(cfg_index_t idx, logic [DIM_W-1:0] value);
      case (idx)
        CFG_SCALE:     scale_reg = value[SCALE_W-1:0];
        CFG_ROW_WIDTH: width_reg = value;
        CFG_ROW_COUNT: count_reg = value;
        default: ;
      endcase
    endfunction

    // Advance the row state for one accepted transaction and queue its run
    function void take_item(logic op, color_t r, color_t g, color_t b);
      run_t        run;
      int unsigned s;
      int unsigned w;
      int unsigned h;
      int unsigned col;
      pixel_t      px;
      logic        replay;
      s      = clamp_to(scale_reg, MAX_SCALE);
      w      = clamp_to(width_reg, LINE_DEPTH);
      h      = clamp_to(count_reg, MAX_ROWS);
      replay = (op == OP_REPLAY);
      run    = '0;
      items_taken++;
      // wrong kind: flag it and leave state alone
      if (replay != (replays_owed != 0)) begin
        run.order_error = 1'b1;
        order_errors++;
        runs_due.push_back(run);
        return;
      end
      col = column % LINE_DEPTH;
      if (replay) begin
        px = line_buf[col];
      end else begin
        px = {b, g, r};
        line_buf[col] = px;
        if (col >= written_depth) written_depth = col + 1;
      end
      run.red    = px[7:0];
      run.green  = px[15:8];
      run.blue   = px[23:16];
      run.copies = s[SCALE_W-1:0];
      if (column + 1 >= w) begin
        run.row_end = 1'b1;
        run.pad     = 2'((w * s) % 4);
        row_ends++;
        column = 0;
        if (replay) replays_owed--;
        else replays_owed = s - 1;
        // last copy of an input row: move to the next row or close the image
        if (replays_owed == 0) begin
          if (row_index + 1 >= h) begin
            run.image_end = 1'b1;
            row_index     = 0;
            image_ends++;
          end else begin
            row_index++;
          end
        end
      end else begin
        column++;
      end
      runs_due.push_back(run);
    endfunction

    function void diff_field(string name, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
      end
    endfunction

    // Compare one result transaction with the oldest run due
    function void match_run(run_t got);
      run_t want;
      if (runs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: run with nothing due: expected none, actual rgb=%02h%02h%02h copies=%0d",
                   $time, got.red, got.green, got.blue, got.copies);
        return;
      end
      want = runs_due.pop_front();
      runs_matched++;
      diff_field("out_red", want.red, got.red);
      diff_field("out_green", want.green, got.green);
      diff_field("out_blue", want.blue, got.blue);
      diff_field("out_copies", want.copies, got.copies);
      diff_field("out_pad_bytes", want.pad, got.pad);
      diff_field("out_row_end", want.row_end, got.row_end);
      diff_field("out_image_end", want.image_end, got.image_end);
      diff_field("out_order_error", want.order_error, got.order_error);
    endfunction
  endclass

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_we       = 1'b0;
  cfg_index_t          cfg_index    = CFG_SCALE;
  logic [DIM_W-1:0]    cfg_data     = '0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                in_operation = OP_PIXEL;
  color_t              in_red       = '0;
  color_t              in_green     = '0;
  color_t              in_blue      = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  color_t              out_red;
  color_t              out_green;
  color_t              out_blue;
  logic [SCALE_W-1:0]  out_copies;
  logic [1:0]          out_pad_bytes;
  logic                out_row_end;
  logic                out_image_end;
  logic                out_order_error;

  int unsigned         sender_idle_pct    = 0;
  int unsigned         receiver_stall_pct = 0;
  bit                  hold_request       = 1'b0;
  pixel_run_tracker    tracker;

  pixel_replication_upscaler dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_copies      (out_copies),
    .out_pad_bytes   (out_pad_bytes),
    .out_row_end     (out_row_end),
    .out_image_end   (out_image_end),
    .out_order_error (out_order_error)
  );

  always #5 clk = ~clk;

  // Receiver: random stall, or a long hold when requested
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  // Check every accepted result transaction
  always @(posedge clk) begin : result_monitor
    run_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.red         = out_red;
      seen.green       = out_green;
      seen.blue        = out_blue;
      seen.copies      = out_copies;
      seen.pad         = out_pad_bytes;
      seen.row_end     = out_row_end;
      seen.image_end   = out_image_end;
      seen.order_error = out_order_error;
      tracker.match_run(seen);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("pixel_replication_upscaler_tb: errors");
    $finish;
  end

  function automatic color_t rand_color();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return color_t'($urandom);
    endcase
  endfunction

  // Offer one transaction after a random gap; hold it until accepted
  task automatic send_item(logic op, color_t r, color_t g, color_t b);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      cfg_we   <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    cfg_we       <= 1'b0;
    in_operation <= op;
    in_red       <= r;
    in_green     <= g;
    in_blue      <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_item(op, r, g, b);
  endtask

  task automatic drive_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every run due, then cover the two-stage pipeline
  task automatic settle();
    while (tracker.runs_due.size() != 0) drive_idle();
    repeat (4) drive_idle();
  endtask

  task automatic write_cfg(cfg_index_t idx, logic [DIM_W-1:0] value);
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    tracker.write_reg(idx, value);
  endtask

  task automatic configure(logic [DIM_W-1:0] sc, logic [DIM_W-1:0] wd, logic [DIM_W-1:0] rc);
    settle();
    write_cfg(CFG_SCALE, sc);
    write_cfg(CFG_ROW_WIDTH, wd);
    write_cfg(CFG_ROW_COUNT, rc);
  endtask

  // Mostly the kind the block expects, with random colors; a few out of order
  task automatic drive_stream(int unsigned count, int unsigned slip_pct);
    logic op;
    for (int unsigned i = 0; i < count; i++) begin
      op = (tracker.replays_owed != 0) ? OP_REPLAY : OP_PIXEL;
      if ($urandom_range(99) < slip_pct) op = ~op;
      send_item(op, rand_color(), rand_color(), rand_color());
    end
  endtask

  // Pick a small random setting; never let owed replays reach unwritten columns
  task automatic random_config();
    logic [DIM_W-1:0] sc;
    logic [DIM_W-1:0] wd;
    logic [DIM_W-1:0] rc;
    case ($urandom_range(11))
      0:       sc = '0;
      1:       sc = DIM_W'(MAX_SCALE);
      2:       sc = DIM_W'(127);
      default: sc = DIM_W'($urandom_range(1, 5));
    endcase
    case ($urandom_range(7))
      0:       wd = '0;
      1:       wd = DIM_W'(1);
      default: wd = DIM_W'($urandom_range(2, 12));
    endcase
    if (sc >= DIM_W'(MAX_SCALE) && wd > DIM_W'(3)) wd = DIM_W'(3);
    if (tracker.replays_owed != 0 && wd > tracker.written_depth)
      wd = DIM_W'(tracker.written_depth);
    rc = DIM_W'($urandom_range(4));
    configure(sc, wd, rc);
  endtask

  initial begin : stimulus
    tracker = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset setting, order errors, a two-row image, zero registers
    send_item(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    send_item(OP_REPLAY, 8'h00, 8'h00, 8'h00);
    configure(3, 2, 2);
    send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    send_item(OP_PIXEL, 8'ha5, 8'h5a, 8'hff);
    send_item(OP_PIXEL, 8'h12, 8'h34, 8'h56);
    repeat (4) send_item(OP_REPLAY, 8'hff, 8'h00, 8'hff);
    send_item(OP_PIXEL, 8'h01, 8'h80, 8'h7f);
    send_item(OP_PIXEL, 8'hfe, 8'h7f, 8'h80);
    repeat (4) send_item(OP_REPLAY, 8'h00, 8'hff, 8'h00);
    configure(0, 0, 0);
    send_item(OP_PIXEL, 8'h5a, 8'ha5, 8'h00);

    // No idling; long output hold while the sender keeps offering, then a full drain
    random_config();
    drive_stream(40, ORDER_SLIP_PCT);
    hold_request = 1'b1;
    drive_stream(50, ORDER_SLIP_PCT);
    settle();
    drive_stream(50, ORDER_SLIP_PCT);

    // Sender gaps, receiver stalls, then both
    sender_idle_pct    = 62;
    receiver_stall_pct = 0;
    repeat (3) begin
      random_config();
      drive_stream(PHASE_ITEMS, ORDER_SLIP_PCT);
    end
    sender_idle_pct    = 0;
    receiver_stall_pct = 62;
    repeat (3) begin
      random_config();
      drive_stream(PHASE_ITEMS, ORDER_SLIP_PCT);
    end
    sender_idle_pct    = 33;
    receiver_stall_pct = 33;
    repeat (3) begin
      random_config();
      drive_stream(PHASE_ITEMS, ORDER_SLIP_PCT);
    end

    // Return to the start of an image with one-pixel rows
    configure(DIM_W'(tracker.scale_reg), 1, 1);
    while (tracker.column != 0 || tracker.replays_owed != 0 || tracker.row_index != 0)
      drive_stream(1, 0);

    // Saturated scale: one pixel, ninety-nine replays
    configure(127, 1, 1);
    drive_stream(100, 0);

    // Saturated width and row count at scale one
    sender_idle_pct    = 20;
    receiver_stall_pct = 20;
    configure(1, 8191, 1);
    drive_stream(SAT_ITEMS, 0);
    configure(1, 1, 8191);
    drive_stream(SAT_ITEMS, 0);

    settle();
    $display("Run covered %0d input transactions and %0d checked runs: %0d out of order,",
             tracker.items_taken, tracker.runs_matched, tracker.order_errors);
    $display("%0d row ends, %0d image ends; settings from zero to saturation, four idle mixes.",
             tracker.row_ends, tracker.image_ends);
    if (tracker.mismatches == 0 && tracker.runs_due.size() == 0) begin
      $display("pixel_replication_upscaler_tb: clean");
    end else begin
      $display("pixel_replication_upscaler_tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pru_pkg.sv
design/pru_ram.sv
design/pixel_replication_upscaler.sv
design/pru_checker.sv
tb/sv/pixel_replication_upscaler_tb.sv
